// ===== sv/mpeg_audio_header_decode_top_defines.svh =====
`ifndef MPEG_AUDIO_HEADER_DECODE_TOP_DEFINES_SVH
`define MPEG_AUDIO_HEADER_DECODE_TOP_DEFINES_SVH

// clocked assertion with explicit clock and reset
`define MAHD_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion on the block clock and reset
`define MAHD_ASSERT(lbl, prop, msg) \
  `MAHD_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== sv/mahd_pkg.sv =====
package mahd_pkg;

  localparam int unsigned PipeDepth   = 4;
  localparam int unsigned XWidth      = 17;
  localparam int unsigned YWidth      = 20;
  localparam int unsigned QWidth      = 12;
  localparam int unsigned RecipWidth  = 27;
  localparam int unsigned RecipShift  = 28;
  localparam int unsigned ProdWidth   = YWidth + RecipWidth;

  localparam logic [RecipWidth-1:0] Recip441 = 27'd608697;
  localparam logic [RecipWidth-1:0] Recip3   = 27'd89478485;
  localparam logic [8:0]            Div441   = 9'd441;
  localparam logic [8:0]            Div3     = 9'd3;
  localparam logic [8:0]            Div1     = 9'd1;

  localparam logic [10:0] SyncWord    = 11'h7FF;
  localparam logic [1:0]  VcodeMpeg1  = 2'b11;
  localparam logic [1:0]  VcodeMpeg2  = 2'b10;
  localparam logic [1:0]  VcodeMpeg25 = 2'b00;
  localparam logic [1:0]  VerMpeg1    = 2'd0;
  localparam logic [1:0]  VerMpeg2    = 2'd1;
  localparam logic [1:0]  VerMpeg25   = 2'd2;
  localparam logic [1:0]  LayerRsvd   = 2'd0;
  localparam logic [1:0]  LayerOne    = 2'd1;
  localparam logic [1:0]  LayerThree  = 2'd3;
  localparam logic [3:0]  BidxBad     = 4'd15;
  localparam logic [1:0]  EmphRsvd    = 2'd2;
  localparam logic [1:0]  ModeMono    = 2'b11;
  localparam logic [10:0] FrameMax    = 11'd2047;

  localparam logic [7:0] CoefL1   = 8'd12;
  localparam logic [7:0] CoefLong = 8'd144;
  localparam logic [7:0] CoefHalf = 8'd72;

  typedef enum logic [1:0] {
    BaseRate44k  = 2'd0,
    BaseRate48k  = 2'd1,
    BaseRate32k  = 2'd2,
    BaseRateRsvd = 2'd3
  } mahd_base_e;

  typedef struct packed {
    mahd_base_e base;
    logic       pad;
    logic       layer1;
    logic       len_en;
  } mahd_len_ctl_t;

  typedef struct packed {
    logic        header_ok;
    logic [1:0]  ver;
    logic [1:0]  layer;
    logic [15:0] sr;
    logic [8:0]  kbps;
    logic [1:0]  chan;
  } mahd_side_t;

  localparam logic [8:0] RateTable [5][16] = '{
    '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
      9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
    '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
    '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
      9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
    '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
    '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
      9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
  };

  function automatic logic [15:0] base_rate_hz(input mahd_base_e sel);
    logic [15:0] hz;
    case (sel)
      BaseRate44k: hz = 16'd44100;
      BaseRate48k: hz = 16'd48000;
      BaseRate32k: hz = 16'd32000;
      default:     hz = 16'd0;
    endcase
    return hz;
  endfunction

  function automatic logic [8:0] kbps_lookup(input logic [2:0] row, input logic [3:0] idx);
    logic [8:0] kb;
    if (row < 3'd5) begin
      kb = RateTable[row][idx];
    end else begin
      kb = 9'd0;
    end
    return kb;
  endfunction

endpackage

// ===== sv/mahd_frame_len.sv =====
module mahd_frame_len
  import mahd_pkg::*;
(
  input  logic                clk_i,
  input  mahd_len_ctl_t       ctl_i,
  input  logic [XWidth-1:0]   x_i,
  output logic [10:0]         len_o
);

  logic [YWidth-1:0]     y_d;
  logic [RecipWidth-1:0] m_d;
  logic [8:0]            div_d;
  logic                  bypass_d;
  logic [ProdWidth-1:0]  prod;
  logic [QWidth-1:0]     q0_d;

  logic [YWidth-1:0]     y_q;
  logic [8:0]            div_q;
  logic [QWidth-1:0]     q0_q;
  mahd_len_ctl_t         ctl2_q;

  logic [YWidth-1:0]     qd_prod;
  logic [YWidth-1:0]     rem;
  logic [QWidth-1:0]     q_d;
  logic [QWidth-1:0]     q_q;
  mahd_len_ctl_t         ctl3_q;

  logic [QWidth:0]       sum;
  logic [QWidth+2:0]     scaled;
  logic [10:0]           len_d;
  logic [10:0]           len_q;

  always_comb begin
    y_d      = '0;
    m_d      = '0;
    div_d    = Div1;
    bypass_d = 1'b0;
    case (ctl_i.base)
      BaseRate44k: begin
        y_d   = YWidth'(x_i) * YWidth'(10);
        m_d   = Recip441;
        div_d = Div441;
      end
      BaseRate48k: begin
        y_d   = YWidth'(x_i >> 4);
        m_d   = Recip3;
        div_d = Div3;
      end
      BaseRate32k: begin
        y_d      = YWidth'(x_i >> 5);
        bypass_d = 1'b1;
      end
      default: begin
        y_d = '0;
      end
    endcase
    prod = ProdWidth'(y_d) * ProdWidth'(m_d);
    q0_d = bypass_d ? y_d[QWidth-1:0] : prod[RecipShift +: QWidth];
  end

  always_ff @(posedge clk_i) begin
    y_q    <= y_d;
    div_q  <= div_d;
    q0_q   <= q0_d;
    ctl2_q <= ctl_i;
  end

  always_comb begin
    qd_prod = YWidth'(q0_q) * YWidth'(div_q);
    rem     = y_q - qd_prod;
    q_d     = (rem >= YWidth'(div_q)) ? q0_q + QWidth'(1) : q0_q;
  end

  always_ff @(posedge clk_i) begin
    q_q    <= q_d;
    ctl3_q <= ctl2_q;
  end

  always_comb begin
    sum    = (QWidth+1)'(q_q) + (QWidth+1)'(ctl3_q.pad);
    scaled = ctl3_q.layer1 ? {sum, 2'b00} : (QWidth+3)'(sum);
    if (!ctl3_q.len_en) begin
      len_d = '0;
    end else if (scaled > (QWidth+3)'(FrameMax)) begin
      len_d = FrameMax;
    end else begin
      len_d = scaled[10:0];
    end
  end

  always_ff @(posedge clk_i) begin
    len_q <= len_d;
  end

  assign len_o = len_q;

endmodule

// ===== sv/mpeg_audio_header_decode_top.sv =====
// MPEG audio frame header decoder. Takes one 32-bit header per cycle on start_i and
// returns its decoded fields with done_o after the input register and the frame length
// path; busy_o is always low, so a new header may be given in every cycle and results
// leave at the same rate. The division by the sample rate in that path is a reciprocal
// multiply (a shift at 32 kHz), a remainder correction and a pad, scale and clamp stage.
module mpeg_audio_header_decode_top
  import mahd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] header_word_i,
  output logic        done_o,
  output logic        header_ok_o,
  output logic [1:0]  mpeg_version_o,
  output logic [1:0]  layer_number_o,
  output logic [15:0] sample_rate_hz_o,
  output logic [8:0]  bitrate_kbps_o,
  output logic [10:0] frame_bytes_o,
  output logic [1:0]  channel_count_o
);

  logic [10:0]       sync;
  logic [1:0]        vcode;
  logic [1:0]        lcode;
  logic [3:0]        bidx;
  logic [1:0]        fidx;
  logic [1:0]        mode;
  logic [1:0]        emph;
  logic              ver_ok;
  logic [2:0]        row;
  logic [7:0]        coef;

  mahd_side_t        side_d;
  mahd_len_ctl_t     ctl_d;
  logic [XWidth-1:0] x_d;

  logic [PipeDepth-1:0] vld_q;
  mahd_side_t           side_q [PipeDepth];
  mahd_len_ctl_t        ctl_q;
  logic [XWidth-1:0]    x_q;
  logic [10:0]          len;

  assign busy_o = 1'b0;

  always_comb begin
    sync  = header_word_i[31:21];
    vcode = header_word_i[20:19];
    lcode = header_word_i[18:17];
    bidx  = header_word_i[15:12];
    fidx  = header_word_i[11:10];
    mode  = header_word_i[7:6];
    emph  = header_word_i[1:0];

    ver_ok     = 1'b1;
    side_d.ver = VerMpeg1;
    case (vcode)
      VcodeMpeg1:  side_d.ver = VerMpeg1;
      VcodeMpeg2:  side_d.ver = VerMpeg2;
      VcodeMpeg25: side_d.ver = VerMpeg25;
      default:     ver_ok     = 1'b0;
    endcase

    side_d.layer = 2'd0 - lcode;
    side_d.sr    = ver_ok ? (base_rate_hz(mahd_base_e'(fidx)) >> side_d.ver) : 16'd0;

    if (side_d.ver == VerMpeg1) begin
      row = 3'(side_d.layer - LayerOne);
    end else begin
      row = (side_d.layer == LayerOne) ? 3'd3 : 3'd4;
    end
    side_d.kbps = (ver_ok && side_d.layer != LayerRsvd) ? kbps_lookup(row, bidx) : 9'd0;

    side_d.chan      = (mode == ModeMono) ? 2'd1 : 2'd2;
    side_d.header_ok = (sync == SyncWord) && ver_ok && (lcode != 2'b00)
                       && (bidx != BidxBad) && (fidx != 2'd3) && (emph != EmphRsvd);

    if (side_d.layer == LayerOne) begin
      coef = CoefL1;
    end else if (side_d.layer == LayerThree && side_d.ver != VerMpeg1) begin
      coef = CoefHalf;
    end else begin
      coef = CoefLong;
    end
    x_d = (XWidth'(coef) * XWidth'(side_d.kbps)) << side_d.ver;

    ctl_d.base   = mahd_base_e'(fidx);
    ctl_d.pad    = header_word_i[9];
    ctl_d.layer1 = (side_d.layer == LayerOne);
    ctl_d.len_en = (side_d.kbps != 9'd0) && (side_d.sr != 16'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[PipeDepth-2:0], start_i && !busy_o};
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_d;
    ctl_q     <= ctl_d;
    x_q       <= x_d;
    for (int i = 1; i < PipeDepth; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  mahd_frame_len u_frame_len (
    .clk_i (clk_i),
    .ctl_i (ctl_q),
    .x_i   (x_q),
    .len_o (len)
  );

  assign done_o           = vld_q[PipeDepth-1];
  assign header_ok_o      = side_q[PipeDepth-1].header_ok;
  assign mpeg_version_o   = side_q[PipeDepth-1].ver;
  assign layer_number_o   = side_q[PipeDepth-1].layer;
  assign sample_rate_hz_o = side_q[PipeDepth-1].sr;
  assign bitrate_kbps_o   = side_q[PipeDepth-1].kbps;
  assign frame_bytes_o    = len;
  assign channel_count_o  = side_q[PipeDepth-1].chan;

endmodule

// ===== sv/mahd_chk.sv =====
`include "mpeg_audio_header_decode_top_defines.svh"

module mahd_chk
  import mahd_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic [31:0] header_word_i,
  input logic        done_o,
  input logic        header_ok_o,
  input logic [1:0]  mpeg_version_o,
  input logic [1:0]  layer_number_o,
  input logic [15:0] sample_rate_hz_o,
  input logic [8:0]  bitrate_kbps_o,
  input logic [10:0] frame_bytes_o,
  input logic [1:0]  channel_count_o
);

  logic [2:0] warm_q;
  logic       warm;
  logic       in_acc;
  logic       hdr_known;

  assign warm      = (warm_q == 3'(PipeDepth));
  assign in_acc    = start_i && !busy_o;
  assign hdr_known = (header_word_i != 32'd0) || (header_word_i == 32'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warm_q <= '0;
    end else if (!warm) begin
      warm_q <= warm_q + 3'd1;
    end
  end

  `MAHD_ASSERT(a_latency, warm && hdr_known |-> (done_o == $past(in_acc, PipeDepth)), "result strobe does not follow accepted item")
  `MAHD_ASSERT(a_len_needs_rates, done_o && (frame_bytes_o != 11'd0) |-> (bitrate_kbps_o != 9'd0) && (sample_rate_hz_o != 16'd0), "frame length without bitrate or sample rate")
  `MAHD_ASSERT(a_ok_fields, done_o && header_ok_o |-> (layer_number_o != 2'd0) && (sample_rate_hz_o != 16'd0) && (mpeg_version_o != 2'd3), "valid header with reserved decoded field")
  `MAHD_ASSERT(a_chan_range, done_o |-> (channel_count_o == 2'd1 || channel_count_o == 2'd2), "channel count out of range")

endmodule

bind mpeg_audio_header_decode_top mahd_chk u_mahd_chk (.*);

// ===== test/mpeg_audio_header_decode_top_tb.sv =====
`timescale 1ns / 100ps

module mpeg_audio_header_decode_top_tb;
  import mahd_pkg::*;

  localparam logic [1:0] VcodeRsvd  = 2'b01;
  localparam logic [3:0] BidxFree   = 4'd0;
  localparam logic [3:0] BidxTop    = 4'd14;
  localparam logic [1:0] ModeStereo = 2'b00;
  localparam logic [1:0] ModeJoint  = 2'b01;
  localparam logic [1:0] ModeDual   = 2'b10;
  localparam logic [2:0] RowLsfL1   = 3'd3;
  localparam logic [2:0] RowLsfL23  = 3'd4;
  localparam int unsigned RandomHeaders = 1030;

  localparam int unsigned SampleBaseHz [4] = '{44100, 48000, 32000, 0};
  localparam int unsigned KbpsTable [5][16] = '{
    '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0},
    '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0},
    '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0},
    '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0},
    '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0}
  };

  typedef struct packed {
    logic        ok;
    logic [1:0]  ver;
    logic [1:0]  layer;
    logic [15:0] sr;
    logic [8:0]  kbps;
    logic [10:0] len;
    logic [1:0]  chan;
  } header_fields_t;

  class header_scoreboard;
    header_fields_t pending[$];
    int unsigned    mismatches;

    function new();
      mismatches = 0;
    endfunction

    function header_fields_t decode(logic [31:0] w);
      header_fields_t res;
      logic [10:0] sync;
      logic [1:0]  vcode, lcode, fidx, mode, emph;
      logic [3:0]  bidx;
      logic        pad, ver_ok;
      int unsigned ver, layer, sr, kbps, len, bps, coef, row;
      sync  = w[31:21];
      vcode = w[20:19];
      lcode = w[18:17];
      bidx  = w[15:12];
      fidx  = w[11:10];
      pad   = w[9];
      mode  = w[7:6];
      emph  = w[1:0];
      ver    = VerMpeg1;
      ver_ok = 1'b1;
      layer  = LayerRsvd;
      sr     = 0;
      kbps   = 0;
      len    = 0;
      case (vcode)
        VcodeMpeg1:  ver = VerMpeg1;
        VcodeMpeg2:  ver = VerMpeg2;
        VcodeMpeg25: ver = VerMpeg25;
        default:     ver_ok = 1'b0;
      endcase
      if (lcode != 2'd0) layer = 4 - lcode;
      if (ver_ok) sr = SampleBaseHz[fidx] >> ver;
      if (ver_ok && layer != LayerRsvd) begin
        if (ver == VerMpeg1) row = layer - 1;
        else row = (layer == LayerOne) ? RowLsfL1 : RowLsfL23;
        kbps = KbpsTable[row][bidx];
      end
      if (kbps != 0 && sr != 0) begin
        bps = kbps * 1000;
        if (layer == LayerOne) begin
          len = (CoefL1 * bps / sr + pad) * 4;
        end else begin
          coef = (layer == LayerThree && ver != VerMpeg1) ? CoefHalf : CoefLong;
          len = coef * bps / sr + pad;
        end
        if (len > FrameMax) len = FrameMax;
      end
      res.ok    = (sync == SyncWord) && ver_ok && (lcode != 2'd0) && (bidx != BidxBad)
                  && (fidx != 2'(BaseRateRsvd)) && (emph != EmphRsvd);
      res.ver   = ver[1:0];
      res.layer = layer[1:0];
      res.sr    = sr[15:0];
      res.kbps  = kbps[8:0];
      res.len   = len[10:0];
      res.chan  = (mode == ModeMono) ? 2'd1 : 2'd2;
      return res;
    endfunction

    function void note_header(logic [31:0] w);
      pending.push_back(decode(w));
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(header_fields_t got);
      header_fields_t want;
      if (pending.size() == 0) begin
        $error("result with no header outstanding");
        mismatches++;
        return;
      end
      want = pending.pop_front();
      compare_field("header_ok", 16'(want.ok), 16'(got.ok));
      compare_field("mpeg_version", 16'(want.ver), 16'(got.ver));
      compare_field("layer_number", 16'(want.layer), 16'(got.layer));
      compare_field("sample_rate_hz", want.sr, got.sr);
      compare_field("bitrate_kbps", 16'(want.kbps), 16'(got.kbps));
      compare_field("frame_bytes", 16'(want.len), 16'(got.len));
      compare_field("channel_count", 16'(want.chan), 16'(got.chan));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [31:0] header_word_i;
  logic        done_o;
  logic        header_ok_o;
  logic [1:0]  mpeg_version_o;
  logic [1:0]  layer_number_o;
  logic [15:0] sample_rate_hz_o;
  logic [8:0]  bitrate_kbps_o;
  logic [10:0] frame_bytes_o;
  logic [1:0]  channel_count_o;

  header_scoreboard sb = new();

  mpeg_audio_header_decode_top DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .header_word_i    (header_word_i),
    .done_o           (done_o),
    .header_ok_o      (header_ok_o),
    .mpeg_version_o   (mpeg_version_o),
    .layer_number_o   (layer_number_o),
    .sample_rate_hz_o (sample_rate_hz_o),
    .bitrate_kbps_o   (bitrate_kbps_o),
    .frame_bytes_o    (frame_bytes_o),
    .channel_count_o  (channel_count_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      sb.check_result('{header_ok_o, mpeg_version_o, layer_number_o, sample_rate_hz_o,
                        bitrate_kbps_o, frame_bytes_o, channel_count_o});
    end
  end

  function automatic logic [31:0] build_header(logic [10:0] sync, logic [1:0] vcode,
                                               logic [1:0] lcode, logic [3:0] bidx,
                                               logic [1:0] fidx, logic pad,
                                               logic [1:0] mode, logic [1:0] emph);
    logic [7:0] misc;
    misc = 8'($urandom());
    return {sync, vcode, lcode, misc[0], bidx, fidx, pad, misc[1], mode, misc[3:2],
            misc[4], misc[5], emph};
  endfunction

  function automatic logic [31:0] random_header();
    logic [10:0] sync;
    logic [1:0]  vcode, lcode, fidx, emph;
    logic [3:0]  bidx;
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 3) return $urandom();
    sync = SyncWord;
    case ($urandom_range(0, 2))
      0:       vcode = VcodeMpeg1;
      1:       vcode = VcodeMpeg2;
      default: vcode = VcodeMpeg25;
    endcase
    lcode = 2'($urandom_range(1, 3));
    bidx  = 4'($urandom_range(1, 14));
    fidx  = 2'($urandom_range(0, 2));
    case ($urandom_range(0, 2))
      0:       emph = 2'd0;
      1:       emph = 2'd1;
      default: emph = 2'd3;
    endcase
    if (pick < 6) begin
      case ($urandom_range(0, 6))
        0:       sync  = 11'($urandom_range(0, 2046));
        1:       vcode = VcodeRsvd;
        2:       lcode = 2'd0;
        3:       bidx  = BidxBad;
        4:       fidx  = 2'(BaseRateRsvd);
        5:       bidx  = BidxFree;
        default: emph  = EmphRsvd;
      endcase
    end
    return build_header(sync, vcode, lcode, bidx, fidx, 1'($urandom()), 2'($urandom()),
                        emph);
  endfunction

  task automatic send_header(input logic [31:0] w, input int unsigned gap);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i       <= 1'b1;
    header_word_i <= w;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note_header(w);
  endtask

  task automatic drain_results(input int unsigned limit);
    int unsigned waited;
    waited = 0;
    start_i <= 1'b0;
    while (sb.pending.size() != 0 && waited < limit) begin
      @(posedge clk_i);
      waited++;
    end
  endtask

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    logic [31:0] plan[$];
    logic        burst;
    rst_ni        <= 1'b0;
    start_i       <= 1'b0;
    header_word_i <= 32'd0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    plan.push_back(32'h0000_0000);
    plan.push_back(32'hFFFF_FFFF);
    plan.push_back(build_header(SyncWord, VcodeMpeg1, 2'b11, BidxTop, 2'd2, 1'b1, ModeMono,
                                2'd0));
    plan.push_back(build_header(SyncWord, VcodeMpeg1, 2'b10, 4'd1, 2'd0, 1'b0, ModeStereo,
                                2'd1));
    plan.push_back(build_header(SyncWord, VcodeMpeg1, 2'b01, 4'd9, 2'd0, 1'b1, ModeJoint,
                                2'd3));
    plan.push_back(build_header(SyncWord, VcodeMpeg2, 2'b11, BidxTop, 2'd1, 1'b0, ModeDual,
                                2'd0));
    plan.push_back(build_header(SyncWord, VcodeMpeg2, 2'b10, 4'd8, 2'd0, 1'b1, ModeStereo,
                                2'd0));
    plan.push_back(build_header(SyncWord, VcodeMpeg2, 2'b01, 4'd8, 2'd2, 1'b0, ModeMono,
                                2'd1));
    plan.push_back(build_header(SyncWord, VcodeMpeg25, 2'b01, 4'd1, 2'd1, 1'b1, ModeJoint,
                                2'd0));
    plan.push_back(build_header(SyncWord, VcodeMpeg25, 2'b10, BidxTop, 2'd2, 1'b1,
                                ModeStereo, 2'd0));
    plan.push_back(build_header(SyncWord, VcodeMpeg25, 2'b11, BidxTop, 2'd2, 1'b1, ModeDual,
                                2'd3));
    plan.push_back(build_header(SyncWord, VcodeRsvd, 2'b01, 4'd5, 2'd0, 1'b0, ModeStereo,
                                2'd0));
    plan.push_back(build_header(SyncWord, VcodeMpeg1, 2'b00, 4'd5, 2'd0, 1'b0, ModeStereo,
                                2'd0));
    plan.push_back(build_header(SyncWord, VcodeMpeg1, 2'b01, BidxBad, 2'd1, 1'b0, ModeMono,
                                2'd0));
    plan.push_back(build_header(SyncWord, VcodeMpeg2, 2'b10, BidxFree, 2'd1, 1'b1,
                                ModeStereo, 2'd0));
    plan.push_back(build_header(SyncWord, VcodeMpeg1, 2'b10, 4'd7, 2'(BaseRateRsvd), 1'b0,
                                ModeJoint, 2'd0));
    plan.push_back(build_header(SyncWord, VcodeMpeg1, 2'b01, 4'd7, 2'd0, 1'b0, ModeStereo,
                                EmphRsvd));
    plan.push_back(build_header(11'h7FE, VcodeMpeg1, 2'b01, 4'd9, 2'd0, 1'b0, ModeStereo,
                                2'd0));
    plan.push_back(build_header(11'h000, VcodeMpeg25, 2'b11, 4'd3, 2'd1, 1'b1, ModeMono,
                                2'd0));
    plan.push_back(build_header(11'h3FF, VcodeRsvd, 2'b00, BidxBad, 2'(BaseRateRsvd), 1'b1,
                                ModeMono, EmphRsvd));

    foreach (plan[i]) send_header(plan[i], $urandom_range(0, 3));
    drain_results(1000);

    burst = 1'b0;
    for (int i = 0; i < RandomHeaders; i++) begin
      if (i % 64 == 0) burst = ($urandom_range(0, 3) == 0);
      if (i == RandomHeaders / 2) drain_results(1000);
      send_header(random_header(), burst ? 0 : $urandom_range(0, 10));
    end

    drain_results(1000);
    if (sb.pending.size() != 0) begin
      $error("%0d results never arrived", sb.pending.size());
      sb.mismatches += sb.pending.size();
    end
    repeat (10) @(posedge clk_i);

    if (sb.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/mahd_pkg.sv
sv/mahd_frame_len.sv
sv/mpeg_audio_header_decode_top.sv
sv/mahd_chk.sv
test/mpeg_audio_header_decode_top_tb.sv
